// ===== sv/adrc_pkg.sv =====
// Shared types, codes and constants of the audio FIFO rate controller.
`default_nettype none

package adrc_pkg;

    localparam int DEF_FIFO_DEPTH  = 16384;
    localparam int DEF_FRAME_WIDTH = 32;
    localparam int QUEUE_DEPTH     = 2;

    localparam int CAP_W      = 15;   // capacity, fill and room
    localparam int CNT_W      = 16;   // index arithmetic before wrap
    localparam int FILL_OUT_W = 14;
    localparam int RATE_W     = 18;
    localparam int SMOOTH_W   = 34;
    localparam int TICK_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int DIV_STEPS  = 16;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int CAP_MIN    = 2;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RATIO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATIO = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD    = 3'd6;

    localparam logic [SMOOTH_W-1:0] RATE_RESET_Q16 = 34'd2890137600; // 44100 Hz in Q16
    localparam logic [16:0]         Q16_ONE        = 17'd65536;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [31:0]      frame_data;
        logic             batch_start;
        logic [CAP_W-1:0] batch_frames;
    } item_t;

    typedef struct packed {
        logic [31:0]           frame_out;
        logic                  frame_valid;
        logic                  write_accepted;
        logic [FILL_OUT_W-1:0] fill_frames;
        logic [RATE_W-1:0]     rate_hz;
        logic                  rate_updated;
    } result_t;

    typedef struct packed {
        logic [CAP_W-1:0]  capacity_frames;
        logic [16:0]       nominal_rate_hz;
        logic [15:0]       gain_q16;
        logic [16:0]       min_ratio_q16;
        logic [16:0]       max_ratio_q16;
        logic [16:0]       smooth_q16;
        logic [TICK_W-1:0] update_period;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        capacity_frames: 15'd12288,
        nominal_rate_hz: 17'd44100,
        gain_q16:        16'd13107,
        min_ratio_q16:   17'd57672,
        max_ratio_q16:   17'd69468,
        smooth_q16:      17'd9830,
        update_period:   8'd8
    };

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_READ,
        KIND_TICK,
        KIND_NOP
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [31:0]      frame_data;
        logic             batch_start;
        logic [CAP_W-1:0] batch_frames;
    } cmd_item_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_TICK
    } back_state_t;

    typedef enum logic [3:0] {
        R_IDLE,
        R_DIV,
        R_RATIO,
        R_CLAMP,
        R_TARGET,
        R_DIFF,
        R_MUL_LO,
        R_MUL_HI,
        R_APPLY,
        R_DONE
    } rate_state_t;

    typedef struct packed {
        logic             tick;
        logic [CAP_W-1:0] fill;
        logic [CAP_W-1:0] cap;
    } rate_req_t;

    typedef struct packed {
        logic              done;
        logic              updated;
        logic [RATE_W-1:0] rate_hz;
    } rate_rsp_t;

    function automatic kind_t classify(input logic [1:0] cmd);
        kind_t k;
        unique case (cmd)
            CMD_WRITE: k = KIND_WRITE;
            CMD_READ:  k = KIND_READ;
            CMD_TICK:  k = KIND_TICK;
            default:   k = KIND_NOP;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== sv/audio_fifo_dynamic_rate_control_unit.sv =====
// Usage:
// Elastic stereo frame FIFO with playback rate control. Items enter on the
// push/full queue port (write frame, read frame, feeder tick); every item gives
// exactly one result on the empty/pop queue port, in order. Registers are
// written on cfg_valid/cfg_ready (ready always high); the user must write them
// only while no item is pending, as the block does not enforce it. Writing the
// capacity register empties the FIFO. A write or an empty read is answered
// from the idle state of the back end, a read of stored audio passes the
// registered frame memory read port, and a tick goes to the rate unit, which
// for an updating tick runs a 16-step fill fraction divider, then two
// multiply-and-clamp steps and a two-part smoothing multiply.
// A 2-entry command queue and a 2-entry result queue separate the sides: when
// pop stays low, up to two results wait and up to two more items are taken
// before full rises.
// Reset: registers to defaults, FIFO empty, rate 44100 Hz; the frame memory is
// not cleared and no item is refused after reset.
`default_nettype none

module audio_fifo_dynamic_rate_control_unit #(
    parameter int FIFO_DEPTH  = adrc_pkg::DEF_FIFO_DEPTH,
    parameter int FRAME_WIDTH = adrc_pkg::DEF_FRAME_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  adrc_pkg::item_t                   item,
    output logic                              full,
    output logic                              empty,
    input  logic                              pop,
    output adrc_pkg::result_t                 result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [adrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adrc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import adrc_pkg::*;

    cfg_t             cfg_reg, cfg_next;
    logic             cfg_write;
    logic             cap_clear;
    logic [CAP_W-1:0] cap_use;

    cmd_item_t        cmd;
    logic             cmd_empty, cmd_pop;
    logic             res_full, res_push;
    result_t          res;
    rate_req_t        rate_req;
    rate_rsp_t        rate_rsp;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cap_clear = cfg_write && (cfg_index == REG_CAPACITY);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CAPACITY:  cfg_next.capacity_frames = cfg_data[CAP_W-1:0];
                REG_NOMINAL:   cfg_next.nominal_rate_hz = cfg_data;
                REG_GAIN:      cfg_next.gain_q16        = cfg_data[15:0];
                REG_MIN_RATIO: cfg_next.min_ratio_q16   = cfg_data;
                REG_MAX_RATIO: cfg_next.max_ratio_q16   = cfg_data;
                REG_SMOOTH:    cfg_next.smooth_q16      = cfg_data;
                REG_PERIOD:    cfg_next.update_period   = cfg_data[TICK_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // capacity in use: at least two, at most the memory depth
    always_comb
    begin
        if (cfg_reg.capacity_frames < CAP_W'(CAP_MIN))
        begin
            cap_use = CAP_W'(CAP_MIN);
        end
        else if (32'(cfg_reg.capacity_frames) > 32'(FIFO_DEPTH))
        begin
            cap_use = CAP_W'(FIFO_DEPTH);
        end
        else
        begin
            cap_use = cfg_reg.capacity_frames;
        end
    end

    adrc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .pop   (cmd_pop),
        .cmd   (cmd),
        .empty (cmd_empty)
    );

    adrc_back #(
        .FIFO_DEPTH  (FIFO_DEPTH),
        .FRAME_WIDTH (FRAME_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_use),
        .cap_clear (cap_clear),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res),
        .rate_req  (rate_req),
        .rate_rsp  (rate_rsp)
    );

    adrc_rate u_rate (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .req   (rate_req),
        .rsp   (rate_rsp)
    );

    adrc_queue #(
        .T     (result_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

`default_nettype wire

// ===== sv/adrc_queue.sv =====
// Small register queue used between the front, back and result ports.
`default_nettype none

module adrc_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    output logic full,
    input  logic pop,
    output T     rdata,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T              slots [DEPTH];
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] rp_reg, rp_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slots[rp_reg];

    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
        end
        if (do_pop)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wp_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== sv/adrc_front.sv =====
// Front end: decodes incoming items and queues them for the back end.
`default_nettype none

module adrc_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  adrc_pkg::item_t       item,
    output logic                  full,
    input  logic                  pop,
    output adrc_pkg::cmd_item_t   cmd,
    output logic                  empty
);
    import adrc_pkg::*;

    cmd_item_t decoded;

    always_comb
    begin
        decoded.kind         = classify(item.cmd);
        decoded.frame_data   = item.frame_data;
        decoded.batch_start  = item.batch_start;
        decoded.batch_frames = item.batch_frames;
    end

    adrc_queue #(
        .T     (cmd_item_t),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (decoded),
        .full  (full),
        .pop   (pop),
        .rdata (cmd),
        .empty (empty)
    );

endmodule

`default_nettype wire

// ===== sv/adrc_rate.sv =====
// Rate control unit: tick counter, fill fraction divider and rate smoothing.
`default_nettype none

module adrc_rate (
    input  logic                clk,
    input  logic                rst_n,
    input  adrc_pkg::cfg_t      cfg,
    input  adrc_pkg::rate_req_t req,
    output adrc_pkg::rate_rsp_t rsp
);
    import adrc_pkg::*;

    rate_state_t         state_reg, state_next;
    logic [TICK_W-1:0]   tick_reg;
    logic [SMOOTH_W-1:0] smooth_reg;
    logic                updated_reg;

    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    quo_reg;
    logic [CAP_W-1:0]    div_cap_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [32:0]         prod_reg;
    logic                neg_reg;
    logic [16:0]         ratio_reg;
    logic [SMOOTH_W-1:0] target_reg;
    logic [SMOOTH_W-1:0] mag_reg;
    logic [SMOOTH_W-1:0] plo_reg;
    logic [SMOOTH_W-1:0] phi_reg;

    logic [TICK_W-1:0]   period;
    logic [TICK_W-1:0]   tick_inc;
    logic                hit;
    logic [CNT_W-1:0]    rem2;
    logic                rem_ge;
    logic [CNT_W-1:0]    rem_step;
    logic [15:0]         dev_mag;
    logic [16:0]         gain2;
    logic [32:0]         prod;
    logic [33:0]         prod_rnd;
    logic [17:0]         ratio_raw;
    logic [17:0]         ratio_lo;
    logic [17:0]         ratio_hi;
    logic [33:0]         target;
    logic                tgt_ge;
    logic [SMOOTH_W-1:0] mag;
    logic [16:0]         k;
    logic [33:0]         plo;
    logic [33:0]         phi;
    logic [50:0]         sum;
    logic [34:0]         corr;
    logic [34:0]         smooth_new;
    logic [34:0]         rate_rnd;

    // tick bookkeeping; a zero period behaves as one
    assign period   = (cfg.update_period == '0) ? TICK_W'(1) : cfg.update_period;
    assign tick_inc = tick_reg + TICK_W'(1);
    assign hit      = (tick_inc >= period);

    // restoring division step: fraction = fill * 65536 / cap
    assign rem2     = {rem_reg[CNT_W-2:0], 1'b0};
    assign rem_ge   = (rem2 >= CNT_W'(div_cap_reg));
    assign rem_step = rem_ge ? rem2 - CNT_W'(div_cap_reg) : rem2;

    // |fraction - 0.5| times twice the gain
    assign dev_mag  = quo_reg[15] ? {1'b0, quo_reg[14:0]} : 16'd32768 - quo_reg;
    assign gain2    = {cfg.gain_q16, 1'b0};
    assign prod     = {17'd0, dev_mag} * {16'd0, gain2};

    // round half away from zero, then clamp to min first and max last
    assign prod_rnd  = {1'b0, prod_reg} + 34'd32768;
    assign ratio_raw = neg_reg ? {1'b0, Q16_ONE} - {1'b0, prod_rnd[32:16]}
                               : {1'b0, Q16_ONE} + {1'b0, prod_rnd[32:16]};
    assign ratio_lo  = (ratio_raw < {1'b0, cfg.min_ratio_q16}) ?
                       {1'b0, cfg.min_ratio_q16} : ratio_raw;
    assign ratio_hi  = (ratio_lo > {1'b0, cfg.max_ratio_q16}) ?
                       {1'b0, cfg.max_ratio_q16} : ratio_lo;

    assign target = {17'd0, cfg.nominal_rate_hz} * {17'd0, ratio_reg};

    assign tgt_ge = (target_reg >= smooth_reg);
    assign mag    = tgt_ge ? target_reg - smooth_reg : smooth_reg - target_reg;

    assign k   = (cfg.smooth_q16 > Q16_ONE) ? Q16_ONE : cfg.smooth_q16;
    // 34-bit magnitude times k, split into two 17-bit halves
    assign plo = {17'd0, mag_reg[16:0]} * {17'd0, k};
    assign phi = {17'd0, mag_reg[33:17]} * {17'd0, k};

    assign sum        = {phi_reg, 17'd0} + {17'd0, plo_reg} + 51'd32768;
    assign corr       = sum[50:16];
    assign smooth_new = neg_reg ? {1'b0, smooth_reg} - corr : {1'b0, smooth_reg} + corr;

    assign rate_rnd = {1'b0, smooth_reg} + 35'd32768;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            R_IDLE:
            begin
                if (req.tick)
                begin
                    state_next = hit ? R_DIV : R_DONE;
                end
            end
            R_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = R_RATIO;
                end
            end
            R_RATIO:  state_next = R_CLAMP;
            R_CLAMP:  state_next = R_TARGET;
            R_TARGET: state_next = R_DIFF;
            R_DIFF:   state_next = R_MUL_LO;
            R_MUL_LO: state_next = R_MUL_HI;
            R_MUL_HI: state_next = R_APPLY;
            R_APPLY:  state_next = R_DONE;
            R_DONE:   state_next = R_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.done    = (state_reg == R_DONE);
        rsp.updated = updated_reg;
        rsp.rate_hz = rate_rnd[33:16];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= R_IDLE;
            tick_reg    <= '0;
            updated_reg <= 1'b0;
            smooth_reg  <= RATE_RESET_Q16;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == R_IDLE && req.tick)
            begin
                tick_reg    <= hit ? '0 : tick_inc;
                updated_reg <= hit;
            end
            if (state_reg == R_APPLY)
            begin
                smooth_reg <= smooth_new[SMOOTH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            R_IDLE:
            begin
                rem_reg     <= {1'b0, req.fill};
                quo_reg     <= '0;
                div_cap_reg <= req.cap;
                step_reg    <= '0;
            end
            R_DIV:
            begin
                rem_reg  <= rem_step;
                quo_reg  <= {quo_reg[CNT_W-2:0], rem_ge};
                step_reg <= step_reg + STEP_W'(1);
            end
            R_RATIO:
            begin
                prod_reg <= prod;
                neg_reg  <= !quo_reg[15];
            end
            R_CLAMP:  ratio_reg  <= ratio_hi[16:0];
            R_TARGET: target_reg <= target;
            R_DIFF:
            begin
                mag_reg <= mag;
                neg_reg <= !tgt_ge;
            end
            R_MUL_LO: plo_reg <= plo;
            R_MUL_HI: phi_reg <= phi;
            R_APPLY, R_DONE:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/adrc_back.sv =====
// Back end: frame store, FIFO indices, batch admission and item sequencing.
`default_nettype none

module adrc_back #(
    parameter int FIFO_DEPTH  = adrc_pkg::DEF_FIFO_DEPTH,
    parameter int FRAME_WIDTH = adrc_pkg::DEF_FRAME_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [adrc_pkg::CAP_W-1:0]   cap,
    input  logic                         cap_clear,
    input  adrc_pkg::cmd_item_t          cmd,
    input  logic                         cmd_empty,
    output logic                         cmd_pop,
    input  logic                         res_full,
    output logic                         res_push,
    output adrc_pkg::result_t            res,
    output adrc_pkg::rate_req_t          rate_req,
    input  adrc_pkg::rate_rsp_t          rate_rsp
);
    import adrc_pkg::*;

    localparam int IW = $clog2(FIFO_DEPTH);

    back_state_t          state_reg, state_next;
    logic [IW-1:0]        wr_idx_reg, rd_idx_reg;
    logic                 batch_reg;
    logic [FRAME_WIDTH-1:0] mem [FIFO_DEPTH];
    logic [FRAME_WIDTH-1:0] rd_data_reg;

    logic [CNT_W-1:0]     w16, r16, cap16;
    logic [CAP_W-1:0]     fill, room;
    logic                 start;
    logic                 batch_next;
    logic                 wr_ok, rd_ok;
    logic                 mem_we, mem_re;
    logic [IW-1:0]        wr_idx_inc, rd_idx_inc;

    assign w16   = CNT_W'(wr_idx_reg);
    assign r16   = CNT_W'(rd_idx_reg);
    assign cap16 = CNT_W'(cap);
    assign fill  = (w16 >= r16) ? CAP_W'(w16 - r16) : CAP_W'(w16 + cap16 - r16);
    assign room  = cap - CAP_W'(1) - fill;

    assign start      = (state_reg == B_IDLE) && !cmd_empty && !res_full;
    assign batch_next = cmd.batch_start ? (cmd.batch_frames <= room) : batch_reg;
    assign wr_ok      = batch_next && (room != '0);
    assign rd_ok      = (fill != '0);

    assign wr_idx_inc = (w16 + CNT_W'(1) == cap16) ? '0 : wr_idx_reg + IW'(1);
    assign rd_idx_inc = (r16 + CNT_W'(1) == cap16) ? '0 : rd_idx_reg + IW'(1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (start && cmd.kind == KIND_READ && rd_ok)
                begin
                    state_next = B_READ;
                end
                else if (start && cmd.kind == KIND_TICK)
                begin
                    state_next = B_TICK;
                end
            end
            B_READ: state_next = B_IDLE;
            B_TICK:
            begin
                if (rate_rsp.done)
                begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_pop            = 1'b0;
        res_push           = 1'b0;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        rate_req.tick      = 1'b0;
        rate_req.fill      = fill;
        rate_req.cap       = cap;
        res.frame_out      = '0;
        res.frame_valid    = 1'b0;
        res.write_accepted = 1'b0;
        res.fill_frames    = fill[FILL_OUT_W-1:0];
        res.rate_hz        = rate_rsp.rate_hz;
        res.rate_updated   = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        KIND_WRITE:
                        begin
                            mem_we             = wr_ok;
                            res_push           = 1'b1;
                            res.write_accepted = wr_ok;
                            res.fill_frames    = FILL_OUT_W'(fill + {{(CAP_W-1){1'b0}}, wr_ok});
                        end
                        KIND_READ:
                        begin
                            mem_re   = rd_ok;
                            res_push = !rd_ok;   // empty read answers with silence at once
                        end
                        KIND_TICK: rate_req.tick = 1'b1;
                        KIND_NOP:  res_push = 1'b1;
                    endcase
                end
            end
            B_READ:
            begin
                res_push        = 1'b1;
                res.frame_out   = 32'(rd_data_reg);
                res.frame_valid = 1'b1;
            end
            B_TICK:
            begin
                res_push         = rate_rsp.done;
                res.rate_updated = rate_rsp.updated;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            batch_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cap_clear)
            begin
                wr_idx_reg <= '0;
                rd_idx_reg <= '0;
                batch_reg  <= 1'b0;
            end
            else
            begin
                if (start && cmd.kind == KIND_WRITE)
                begin
                    batch_reg <= batch_next;
                end
                if (mem_we)
                begin
                    wr_idx_reg <= wr_idx_inc;
                end
                if (mem_re)
                begin
                    rd_idx_reg <= rd_idx_inc;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_idx_reg] <= FRAME_WIDTH'(cmd.frame_data);
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

endmodule

`default_nettype wire

// ===== sv/adrc_check.sv =====
// Port-level checker for the rate controller, bound to the top level.
`default_nettype none

module adrc_check (
    input logic              clk,
    input logic              rst_n,
    input logic              push,
    input logic              full,
    input logic              empty,
    input logic              pop,
    input adrc_pkg::result_t result
);

    // transactions accepted on input but not yet delivered
    logic [2:0] outstanding_reg, outstanding_next;

    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (push && !full && !(pop && !empty))
        begin
            outstanding_next = outstanding_reg + 3'd1;
        end
        else if (!(push && !full) && pop && !empty)
        begin
            outstanding_next = outstanding_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= 3'd0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    a_empty_after_reset: assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result port not empty after reset");

    a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg == 3'd0 |-> empty)
        else $error("result shown with no transaction pending");

    // two queued commands, one in the back end or two queued results
    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        outstanding_reg <= 3'd4)
        else $error("more transactions pending than the queues hold");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(result))
        else $error("waiting result changed or vanished");

endmodule

bind audio_fifo_dynamic_rate_control_unit adrc_check u_adrc_check (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

`default_nettype wire

// ===== test/audio_fifo_rate_checker.sv =====
// Checker for the audio FIFO rate controller: predicts every result and compares it.
module audio_fifo_rate_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic                              full,
    input  adrc_pkg::item_t                   item,
    input  logic                              pop,
    input  logic                              empty,
    input  adrc_pkg::result_t                 result,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [adrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [adrc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                                mismatches,
    output int                                outstanding,
    output int                                results_checked,
    output int                                rate_updates,
    output int                                dropped_writes,
    output int                                silent_reads
);
    timeunit 1ns;
    timeprecision 1ps;

    import adrc_pkg::*;

    localparam longint RATE_MASK = (64'd1 << SMOOTH_W) - 1;
    localparam longint Q16_HALF  = 32768;
    localparam longint UNITY     = 65536;

    // register copy
    longint capacity, nominal, gain, min_ratio, max_ratio, smooth, period;
    // FIFO and rate loop state
    longint      wr_pos, rd_pos, ticks, rate_q16;
    bit          batch_ok;
    logic [31:0] frame_mem [DEF_FIFO_DEPTH];

    result_t awaited_results [$];

    function automatic longint cap_in_use();
        longint c;
        c = capacity;
        if (c < CAP_MIN)
            c = CAP_MIN;
        if (c > DEF_FIFO_DEPTH)
            c = DEF_FIFO_DEPTH;
        return c;
    endfunction

    function automatic longint fill_level();
        longint c;
        c = cap_in_use();
        return (wr_pos + c - rd_pos) % c;
    endfunction

    // v * k / 2^16, rounded to nearest, halves away from zero
    function automatic longint scale_q16(longint v, longint k);
        longint mag;
        mag = (v < 0) ? -v : v;
        mag = (mag * k + Q16_HALF) >>> 16;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic void retune_rate();
        longint frac, ratio, target, coef;
        frac  = (fill_level() << 16) / cap_in_use();
        ratio = UNITY + scale_q16(frac - Q16_HALF, 2 * gain);
        // min first, so max wins when the limits cross
        if (ratio < min_ratio)
            ratio = min_ratio;
        if (ratio > max_ratio)
            ratio = max_ratio;
        target   = nominal * ratio;
        coef     = (smooth > UNITY) ? UNITY : smooth;
        rate_q16 = (rate_q16 + scale_q16(target - rate_q16, coef)) & RATE_MASK;
    endfunction

    function automatic result_t advance(item_t it);
        result_t r;
        longint  c, room, bsize, per;
        r = '0;
        c = cap_in_use();
        case (it.cmd)
            CMD_WRITE:
            begin
                room  = c - 1 - fill_level();
                bsize = it.batch_frames;
                if (it.batch_start)
                    batch_ok = (bsize <= room);
                if (batch_ok && room > 0)
                begin
                    frame_mem[wr_pos] = it.frame_data;
                    wr_pos            = (wr_pos + 1) % c;
                    r.write_accepted  = 1'b1;
                end
            end
            CMD_READ:
            begin
                if (fill_level() != 0)
                begin
                    r.frame_out   = frame_mem[rd_pos];
                    rd_pos        = (rd_pos + 1) % c;
                    r.frame_valid = 1'b1;
                end
            end
            CMD_TICK:
            begin
                per   = (period == 0) ? 1 : period;
                ticks = (ticks + 1) & 255;
                if (ticks >= per)
                begin
                    ticks = 0;
                    retune_rate();
                    r.rate_updated = 1'b1;
                end
            end
            default: ;
        endcase
        r.fill_frames = FILL_OUT_W'(fill_level());
        r.rate_hz     = RATE_W'((rate_q16 + Q16_HALF) >>> 16);
        return r;
    endfunction

    function automatic void load_defaults();
        capacity  = CFG_RESET.capacity_frames;
        nominal   = CFG_RESET.nominal_rate_hz;
        gain      = CFG_RESET.gain_q16;
        min_ratio = CFG_RESET.min_ratio_q16;
        max_ratio = CFG_RESET.max_ratio_q16;
        smooth    = CFG_RESET.smooth_q16;
        period    = CFG_RESET.update_period;
        wr_pos    = 0;
        rd_pos    = 0;
        ticks     = 0;
        batch_ok  = 1'b0;
        rate_q16  = RATE_RESET_Q16;
    endfunction

    function automatic void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_CAPACITY:
            begin
                // new capacity empties the FIFO
                capacity = data[CAP_W-1:0];
                wr_pos   = 0;
                rd_pos   = 0;
                batch_ok = 1'b0;
            end
            REG_NOMINAL:   nominal   = data;
            REG_GAIN:      gain      = data[15:0];
            REG_MIN_RATIO: min_ratio = data;
            REG_MAX_RATIO: max_ratio = data;
            REG_SMOOTH:    smooth    = data;
            REG_PERIOD:    period    = data[TICK_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            load_defaults();
            awaited_results.delete();
            mismatches      = 0;
            results_checked = 0;
            rate_updates    = 0;
            dropped_writes  = 0;
            silent_reads    = 0;
            outstanding    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                write_reg(cfg_index, cfg_data);
            if (pop && !empty)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result transaction with no item outstanding");
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("frame_out", want.frame_out, result.frame_out);
                    check_field("frame_valid", want.frame_valid, result.frame_valid);
                    check_field("write_accepted", want.write_accepted, result.write_accepted);
                    check_field("fill_frames", want.fill_frames, result.fill_frames);
                    check_field("rate_hz", want.rate_hz, result.rate_hz);
                    check_field("rate_updated", want.rate_updated, result.rate_updated);
                    results_checked++;
                end
            end
            if (push && !full)
            begin
                want = advance(item);
                awaited_results.push_back(want);
                if (item.cmd == CMD_WRITE && !want.write_accepted)
                    dropped_writes++;
                if (item.cmd == CMD_READ && !want.frame_valid)
                    silent_reads++;
                if (want.rate_updated)
                    rate_updates++;
            end
            outstanding <= awaited_results.size();
        end
    end

endmodule

// ===== test/tb_audio_fifo_dynamic_rate_control_unit.sv =====
// Testbench top: directed and random traffic into the audio FIFO rate controller.
module tb_audio_fifo_dynamic_rate_control_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import adrc_pkg::*;

    localparam logic [1:0]           CMD_NONE     = 2'd3;   // unused command code
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd7;   // index with no register
    localparam int                   STALL_LIMIT  = 3000;
    localparam int                   DRAIN_CYCLES = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    item_t                 item;
    logic                  empty;
    logic                  pop;
    result_t               result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches, outstanding, results_checked, rate_updates, dropped_writes, silent_reads;
    int items_sent    = 0;
    int settings_used = 0;
    int idle_cycles   = 0;
    bit calm          = 1'b0;

    audio_fifo_dynamic_rate_control_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    audio_fifo_rate_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .item            (item),
        .pop             (pop),
        .empty           (empty),
        .result          (result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked),
        .rate_updates    (rate_updates),
        .dropped_writes  (dropped_writes),
        .silent_reads    (silent_reads)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // no transaction of any kind for too long means a hang
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // result side: random stalls between pop bursts
    initial
    begin
        int stall;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = pick_gap(1'b0);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(60, 200)) @(posedge clk);
            else
                repeat ($urandom_range(1, 30)) @(posedge clk);
        end
    end

    // push stays high into the next item when no gap follows
    task automatic send(logic [1:0] cmd, logic [31:0] data, logic bstart,
                        logic [CAP_W-1:0] bframes);
        item_t it;
        int    gap;
        it.cmd          = cmd;
        it.frame_data   = data;
        it.batch_start  = bstart;
        it.batch_frames = bframes;
        push <= 1'b1;
        item <= it;
        do @(posedge clk); while (full);
        items_sent++;
        gap = pick_gap(calm);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] cap, logic [CFG_DATA_W-1:0] nom,
                             logic [CFG_DATA_W-1:0] gain, logic [CFG_DATA_W-1:0] lo,
                             logic [CFG_DATA_W-1:0] hi, logic [CFG_DATA_W-1:0] smooth,
                             logic [CFG_DATA_W-1:0] per);
        settle();
        set_reg(REG_CAPACITY, cap);
        set_reg(REG_NOMINAL, nom);
        set_reg(REG_GAIN, gain);
        set_reg(REG_MIN_RATIO, lo);
        set_reg(REG_MAX_RATIO, hi);
        set_reg(REG_SMOOTH, smooth);
        set_reg(REG_PERIOD, per);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // batches with random content, alternating fill and drain windows
    task automatic traffic(int n, int cap);
        int               k, remaining, wr_pct, pick, bsize;
        logic [1:0]       cmd;
        logic             bstart;
        logic [CAP_W-1:0] bframes;
        remaining = 0;
        wr_pct    = 25;
        for (k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
            begin
                wr_pct = (wr_pct == 70) ? 25 : 70;
                calm   = ($urandom_range(0, 3) == 0);
            end
            bstart  = 1'($urandom_range(0, 1));
            bframes = CAP_W'($urandom_range(0, 32767));
            pick    = $urandom_range(0, 99);
            if (pick < 2)
                cmd = CMD_NONE;
            else if (pick < 17)
                cmd = CMD_TICK;
            else if ($urandom_range(0, 99) >= wr_pct)
                cmd = CMD_READ;
            else
            begin
                cmd = CMD_WRITE;
                if (remaining > 0)
                begin
                    bstart = 1'b0;
                    remaining--;
                end
                else if ($urandom_range(0, 9) == 0)
                    bstart = 1'b0;    // stray write outside any batch
                else
                begin
                    bstart = 1'b1;
                    pick   = $urandom_range(0, 99);
                    if (pick < 8)
                        bsize = 0;
                    else if (pick < 90)
                        bsize = $urandom_range(1, (cap < 24) ? cap : 24);
                    else
                        bsize = $urandom_range(cap, 32767);
                    bframes   = CAP_W'(bsize);
                    // oversized or empty batches get a short broken tail
                    remaining = (bsize > 24 || bsize == 0) ? $urandom_range(0, 6) : bsize - 1;
                end
            end
            send(cmd, $urandom, bstart, bframes);
        end
        calm = 1'b0;
    endtask

    initial
    begin
        int cap, k;
        push      <= 1'b0;
        item      <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        rst_n     <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers: capacity 12288, period 8
        send(CMD_WRITE, 32'hFFFF_FFFF, 1'b0, 15'h7FFF);   // no batch yet, dropped
        send(CMD_READ, 32'h0, 1'b0, 15'h0);               // empty: silence
        send(CMD_NONE, 32'hFFFF_FFFF, 1'b1, 15'h7FFF);
        send(CMD_WRITE, 32'h0, 1'b1, 15'h0);              // zero-length batch
        send(CMD_WRITE, 32'h5A5A_5A5A, 1'b1, 15'h7FFF);   // too big, whole batch dropped
        send(CMD_WRITE, 32'h1234_5678, 1'b0, 15'h0);
        send(CMD_WRITE, 32'hFFFF_FFFF, 1'b1, 15'd12286);  // exactly the free space
        send(CMD_WRITE, 32'hA5A5_A5A5, 1'b0, 15'd1);
        repeat (4) send(CMD_READ, 32'h0, 1'b0, 15'h0);
        repeat (8) send(CMD_TICK, 32'h0, 1'b0, 15'h0);

        // smallest FIFO, zero period, ratio pinned to zero, zero smoothing factor
        configure(2, 8000, 0, 0, 0, 0, 0);
        send(CMD_WRITE, 32'hC0DE_C0DE, 1'b1, 15'd1);
        send(CMD_WRITE, 32'h0BAD_F00D, 1'b0, 15'd1);     // batch accepted but full
        send(CMD_TICK, 32'h0, 1'b0, 15'h0);
        send(CMD_READ, 32'h0, 1'b0, 15'h0);
        send(CMD_READ, 32'h0, 1'b0, 15'h0);

        settle();
        set_reg(REG_SPARE, 17'h1_FFFF);
        cfg_valid <= 1'b0;

        // capacity below range, crossed limits, saturated smoothing
        configure(1, 96000, 65535, 131071, 0, 131071, 1);
        traffic(60, 2);
        // capacity above the memory, longest period
        configure(32767, 22050, 13107, 57672, 69468, 9830, 255);
        traffic(80, DEF_FIFO_DEPTH);
        configure(5, 48000, 40000, 50000, 80000, 30000, 2);
        traffic(80, 5);
        configure(16, 8000, 65535, 0, 131071, 65536, 1);
        traffic(80, 16);
        configure(CFG_DATA_W'(CFG_RESET.capacity_frames), CFG_RESET.nominal_rate_hz,
                  CFG_DATA_W'(CFG_RESET.gain_q16), CFG_RESET.min_ratio_q16,
                  CFG_RESET.max_ratio_q16, CFG_RESET.smooth_q16,
                  CFG_DATA_W'(CFG_RESET.update_period));
        traffic(60, int'(CFG_RESET.capacity_frames));

        for (k = 0; k < 10; k++)
        begin
            case ($urandom_range(0, 9))
                0:       cap = $urandom_range(0, 1);
                1, 2:    cap = $urandom_range(41, 600);
                default: cap = $urandom_range(2, 40);
            endcase
            configure(CFG_DATA_W'(cap), CFG_DATA_W'($urandom_range(8000, 96000)),
                      CFG_DATA_W'($urandom_range(0, 65535)),
                      CFG_DATA_W'($urandom_range(40000, 70000)),
                      CFG_DATA_W'($urandom_range(60000, 100000)),
                      CFG_DATA_W'($urandom_range(0, 65536)),
                      CFG_DATA_W'($urandom_range(1, 12)));
            traffic(75, (cap < CAP_MIN) ? CAP_MIN : cap);
        end

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d items over %0d register settings, %0d results checked.",
                 items_sent, settings_used, results_checked);
        $display("It saw %0d rate updates, %0d dropped writes and %0d silent reads.",
                 rate_updates, dropped_writes, silent_reads);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
